### rtl/ireq_pkg.sv
// ireq_pkg: shared types and constants of the input report to event queue block
// holds sequencer states, push steps, event kinds and entry layout
// no dependencies
package ireq_pkg;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PUSH,
        ST_RD_ISSUE,
        ST_RD_WAIT,
        ST_RD_OUT
    } ireq_state_t;

    // one push slot per cycle while a poll is worked off
    typedef enum logic [2:0] {
        STEP_KEY,
        STEP_KBD_SYNC,
        STEP_REL_X,
        STEP_REL_Y,
        STEP_BTN_LEFT,
        STEP_BTN_RIGHT,
        STEP_MOUSE_SYNC
    } push_step_t;

    localparam int NUM_STEPS = 7;

    // event kinds
    localparam logic [1:0] KIND_SYNC = 2'd0;
    localparam logic [1:0] KIND_KEY  = 2'd1;
    localparam logic [1:0] KIND_REL  = 2'd2;

    // event codes
    localparam logic [15:0] CODE_AXIS_X    = 16'h0000;
    localparam logic [15:0] CODE_AXIS_Y    = 16'h0001;
    localparam logic [15:0] CODE_BTN_LEFT  = 16'h0110;
    localparam logic [15:0] CODE_BTN_RIGHT = 16'h0111;

    // timestamp clock
    localparam logic [19:0] MICROS_STEP = 20'd1000;
    localparam logic [19:0] MICROS_WRAP = 20'd1000000;

    // ring entry: seconds, micros, kind, code, value
    localparam int SEC_W   = 32;
    localparam int MIC_W   = 20;
    localparam int KIND_W  = 2;
    localparam int CODE_W  = 16;
    localparam int VAL_W   = 17;
    localparam int ENTRY_W = SEC_W + MIC_W + KIND_W + CODE_W + VAL_W;

endpackage

### rtl/ireq_ram.sv
// ireq_ram: generic simple dual-port RAM, one write and one registered read port
// no dependencies
module ireq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/input_report_to_event_queue_core.sv
// input report to event queue: top level with sequencer, clock and two event rings
// depends on ireq_pkg and ireq_ram (one RAM holds both rings)
// A poll is accepted, then takes one ring push slot per cycle over seven slots through
// the single RAM write port. A read pops each event through RAM read, register and output
// beat; an empty read goes from the accept straight to its output beat. Every output beat
// waits until the output side takes it.
// Reset clears the clock, the previous mouse report, all ring pointers and fill counts;
// ring contents are not cleared and are only read after being written.
module input_report_to_event_queue_core #(
    parameter int RING_DEPTH = 128,
    parameter int MAX_READ   = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               func,
    input  logic               key_valid,
    input  logic signed [16:0] key_value,
    input  logic               mouse_valid,
    input  logic [15:0]        mouse_x,
    input  logic [15:0]        mouse_y,
    input  logic [7:0]         mouse_buttons,
    input  logic               device_select,
    input  logic [6:0]         read_limit,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               event_valid,
    output logic [31:0]        stamp_seconds,
    output logic [19:0]        stamp_micros,
    output logic [1:0]         event_kind,
    output logic [15:0]        event_code,
    output logic signed [16:0] event_value,
    output logic               last_of_read
);

    import ireq_pkg::*;

    localparam int PTR_W  = $clog2(RING_DEPTH);
    localparam int FILL_W = $clog2(RING_DEPTH + 1);
    localparam int ADDR_W = PTR_W + 1;
    localparam int REM_W  = $clog2(MAX_READ + 1);
    localparam int CMP_W  = (FILL_W > 7) ? FILL_W : 7;

    // control state
    ireq_state_t         state_reg, state_next;
    push_step_t          step_reg, step_next;
    logic [NUM_STEPS-1:0] push_mask_reg, push_mask_next;
    logic [31:0]         sec_reg, sec_next;
    logic [19:0]         mic_reg, mic_next;
    logic [15:0]         prev_x_reg, prev_x_next;
    logic [15:0]         prev_y_reg, prev_y_next;
    logic [7:0]          prev_btn_reg, prev_btn_next;
    logic [PTR_W-1:0]    rp_reg [2];
    logic [PTR_W-1:0]    rp_next [2];
    logic [PTR_W-1:0]    wp_reg [2];
    logic [PTR_W-1:0]    wp_next [2];
    logic [FILL_W-1:0]   fill_reg [2];
    logic [FILL_W-1:0]   fill_next [2];
    logic                dev_reg, dev_next;
    logic [REM_W-1:0]    remain_reg, remain_next;

    // poll payload held while pushing
    logic [15:0]         key_code_reg, key_code_next;
    logic                key_press_reg, key_press_next;
    logic [16:0]         dx_reg, dx_next;
    logic [16:0]         dy_reg, dy_next;
    logic [1:0]          btn_reg, btn_next;

    // output beat registers
    logic                ev_valid_reg, ev_valid_next;
    logic [31:0]         o_sec_reg, o_sec_next;
    logic [19:0]         o_mic_reg, o_mic_next;
    logic [1:0]          o_kind_reg, o_kind_next;
    logic [15:0]         o_code_reg, o_code_next;
    logic [16:0]         o_val_reg, o_val_next;
    logic                o_last_reg, o_last_next;

    // ram ports
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic                ram_re;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0]  ram_rdata;

    // one ring per half of the address space
    ireq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (2 ** ADDR_W)
    ) u_ring_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // sequencer and next values
    always_comb
    begin
        logic [19:0]      mic_sum;
        logic [16:0]      key_neg_val;
        logic             key_neg;
        logic             moved;
        logic [CMP_W-1:0] lim;
        logic [CMP_W-1:0] fill_ext;
        logic [CMP_W-1:0] n_pop;
        logic             step_dev;
        logic [1:0]       w_kind;
        logic [15:0]      w_code;
        logic [16:0]      w_val;

        state_next     = state_reg;
        step_next      = step_reg;
        push_mask_next = push_mask_reg;
        sec_next       = sec_reg;
        mic_next       = mic_reg;
        prev_x_next    = prev_x_reg;
        prev_y_next    = prev_y_reg;
        prev_btn_next  = prev_btn_reg;
        rp_next        = rp_reg;
        wp_next        = wp_reg;
        fill_next      = fill_reg;
        dev_next       = dev_reg;
        remain_next    = remain_reg;
        key_code_next  = key_code_reg;
        key_press_next = key_press_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        btn_next       = btn_reg;
        ev_valid_next  = ev_valid_reg;
        o_sec_next     = o_sec_reg;
        o_mic_next     = o_mic_reg;
        o_kind_next    = o_kind_reg;
        o_code_next    = o_code_reg;
        o_val_next     = o_val_reg;
        o_last_next    = o_last_reg;

        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_raddr = {dev_reg, rp_reg[dev_reg]};

        mic_sum     = mic_reg + MICROS_STEP;
        key_neg     = key_value[16];
        key_neg_val = 17'd0 - key_value;
        moved       = (mouse_x != prev_x_reg) || (mouse_y != prev_y_reg);

        lim      = (read_limit > 7'(MAX_READ)) ? CMP_W'(MAX_READ) : CMP_W'(read_limit);
        fill_ext = CMP_W'(fill_reg[device_select]);
        n_pop    = (lim < fill_ext) ? lim : fill_ext;

        // push slot decode
        step_dev = (step_reg != STEP_KEY) && (step_reg != STEP_KBD_SYNC);
        case (step_reg)
            STEP_KEY:
            begin
                w_kind = KIND_KEY;
                w_code = key_code_reg;
                w_val  = {16'd0, key_press_reg};
            end
            STEP_REL_X:
            begin
                w_kind = KIND_REL;
                w_code = CODE_AXIS_X;
                w_val  = dx_reg;
            end
            STEP_REL_Y:
            begin
                w_kind = KIND_REL;
                w_code = CODE_AXIS_Y;
                w_val  = dy_reg;
            end
            STEP_BTN_LEFT:
            begin
                w_kind = KIND_KEY;
                w_code = CODE_BTN_LEFT;
                w_val  = {16'd0, btn_reg[0]};
            end
            STEP_BTN_RIGHT:
            begin
                w_kind = KIND_KEY;
                w_code = CODE_BTN_RIGHT;
                w_val  = {16'd0, btn_reg[1]};
            end
            default:
            begin
                w_kind = KIND_SYNC;
                w_code = 16'd0;
                w_val  = 17'd0;
            end
        endcase
        ram_waddr = {step_dev, wp_reg[step_dev]};
        ram_wdata = {sec_reg, mic_reg, w_kind, w_code, w_val};

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (func)
                    begin
                        dev_next = device_select;
                        if (n_pop == '0)
                        begin
                            ev_valid_next = 1'b0;
                            o_sec_next    = '0;
                            o_mic_next    = '0;
                            o_kind_next   = '0;
                            o_code_next   = '0;
                            o_val_next    = '0;
                            o_last_next   = 1'b1;
                            state_next    = ST_RD_OUT;
                        end
                        else
                        begin
                            remain_next = REM_W'(n_pop);
                            state_next  = ST_RD_ISSUE;
                        end
                    end
                    else
                    begin
                        // advance the clock by one millisecond
                        if (mic_sum >= MICROS_WRAP)
                        begin
                            mic_next = mic_sum - MICROS_WRAP;
                            sec_next = sec_reg + 32'd1;
                        end
                        else
                        begin
                            mic_next = mic_sum;
                        end
                        // key report
                        key_code_next  = key_neg ? key_neg_val[15:0] : key_value[15:0];
                        key_press_next = !key_neg;
                        push_mask_next[STEP_KEY]      = key_valid && (key_value != '0);
                        push_mask_next[STEP_KBD_SYNC] = key_valid && (key_value != '0);
                        // mouse report
                        dx_next  = {1'b0, mouse_x} - {1'b0, prev_x_reg};
                        dy_next  = {1'b0, mouse_y} - {1'b0, prev_y_reg};
                        btn_next = mouse_buttons[1:0];
                        push_mask_next[STEP_REL_X]  = mouse_valid && moved;
                        push_mask_next[STEP_REL_Y]  = mouse_valid && moved;
                        push_mask_next[STEP_BTN_LEFT] =
                            mouse_valid && (mouse_buttons[0] != prev_btn_reg[0]);
                        push_mask_next[STEP_BTN_RIGHT] =
                            mouse_valid && (mouse_buttons[1] != prev_btn_reg[1]);
                        push_mask_next[STEP_MOUSE_SYNC] =
                            mouse_valid && (moved || (mouse_buttons != prev_btn_reg));
                        if (mouse_valid)
                        begin
                            prev_x_next   = mouse_x;
                            prev_y_next   = mouse_y;
                            prev_btn_next = mouse_buttons;
                        end
                        step_next  = STEP_KEY;
                        state_next = ST_PUSH;
                    end
                end
            end
            ST_PUSH:
            begin
                // one ring push per slot, dropped when the ring is full
                if (push_mask_reg[step_reg] && (fill_reg[step_dev] != FILL_W'(RING_DEPTH)))
                begin
                    ram_we = 1'b1;
                    wp_next[step_dev] = (wp_reg[step_dev] == PTR_W'(RING_DEPTH - 1)) ?
                                        '0 : wp_reg[step_dev] + PTR_W'(1);
                    fill_next[step_dev] = fill_reg[step_dev] + FILL_W'(1);
                end
                if (step_reg == STEP_MOUSE_SYNC)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    step_next = push_step_t'(3'(step_reg) + 3'd1);
                end
            end
            ST_RD_ISSUE:
            begin
                ram_re = 1'b1;
                rp_next[dev_reg] = (rp_reg[dev_reg] == PTR_W'(RING_DEPTH - 1)) ?
                                   '0 : rp_reg[dev_reg] + PTR_W'(1);
                fill_next[dev_reg] = fill_reg[dev_reg] - FILL_W'(1);
                remain_next = remain_reg - REM_W'(1);
                state_next  = ST_RD_WAIT;
            end
            ST_RD_WAIT:
            begin
                ev_valid_next = 1'b1;
                o_sec_next    = ram_rdata[ENTRY_W-1 -: SEC_W];
                o_mic_next    = ram_rdata[KIND_W+CODE_W+VAL_W +: MIC_W];
                o_kind_next   = ram_rdata[CODE_W+VAL_W +: KIND_W];
                o_code_next   = ram_rdata[VAL_W +: CODE_W];
                o_val_next    = ram_rdata[VAL_W-1:0];
                o_last_next   = (remain_reg == '0);
                state_next    = ST_RD_OUT;
            end
            ST_RD_OUT:
            begin
                if (out_ready)
                begin
                    state_next = o_last_reg ? ST_IDLE : ST_RD_ISSUE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= STEP_KEY;
            push_mask_reg <= '0;
            sec_reg       <= '0;
            mic_reg       <= '0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            prev_btn_reg  <= '0;
            rp_reg        <= '{default: '0};
            wp_reg        <= '{default: '0};
            fill_reg      <= '{default: '0};
            dev_reg       <= 1'b0;
            remain_reg    <= '0;
            ev_valid_reg  <= 1'b0;
            o_last_reg    <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            push_mask_reg <= push_mask_next;
            sec_reg       <= sec_next;
            mic_reg       <= mic_next;
            prev_x_reg    <= prev_x_next;
            prev_y_reg    <= prev_y_next;
            prev_btn_reg  <= prev_btn_next;
            rp_reg        <= rp_next;
            wp_reg        <= wp_next;
            fill_reg      <= fill_next;
            dev_reg       <= dev_next;
            remain_reg    <= remain_next;
            ev_valid_reg  <= ev_valid_next;
            o_last_reg    <= o_last_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        key_code_reg  <= key_code_next;
        key_press_reg <= key_press_next;
        dx_reg        <= dx_next;
        dy_reg        <= dy_next;
        btn_reg       <= btn_next;
        o_sec_reg     <= o_sec_next;
        o_mic_reg     <= o_mic_next;
        o_kind_reg    <= o_kind_next;
        o_code_reg    <= o_code_next;
        o_val_reg     <= o_val_next;
    end

    // ports
    assign in_ready      = (state_reg == ST_IDLE);
    assign out_valid     = (state_reg == ST_RD_OUT);
    assign event_valid   = ev_valid_reg;
    assign stamp_seconds = o_sec_reg;
    assign stamp_micros  = o_mic_reg;
    assign event_kind    = o_kind_reg;
    assign event_code    = o_code_reg;
    assign event_value   = o_val_reg;
    assign last_of_read  = o_last_reg;

    // fill counts never pass the ring depth
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg[0] <= FILL_W'(RING_DEPTH)) && (fill_reg[1] <= FILL_W'(RING_DEPTH)))
        else $error("ring fill count beyond depth");

    // input and output sides never open together
    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready while output beat pending");

    // an empty read beat closes the read
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !event_valid) |-> last_of_read)
        else $error("empty read beat without last");

    // a pop only ever hits a non-empty ring
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD_ISSUE) |-> (fill_reg[dev_reg] != '0))
        else $error("pop from empty ring");

    // a popped beat is followed by a beat on the output
    a_pop_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD_ISSUE) |=> ##1 (out_valid && event_valid))
        else $error("pop without output beat");

endmodule

### tb/ireq_tb_pkg.sv
`timescale 1ns / 1ps
// ireq_tb_pkg: request codes and sizes shared by the event queue testbench files
// no dependencies

package ireq_tb_pkg;

    // request function
    localparam logic FUNC_POLL = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    // ring selection
    localparam logic DEV_KBD   = 1'b0;
    localparam logic DEV_MOUSE = 1'b1;

    // sizes matching the block's default parameters
    localparam int MAX_READ_LIMIT = 64;
    localparam int RING_SIZE      = 128;

endpackage

### tb/event_queue_checker.sv
`timescale 1ns / 1ps
// event_queue_checker: watches both channels, predicts popped events and compares them
// depends on ireq_pkg (kinds, codes, clock step) and ireq_tb_pkg (request codes, sizes)

module event_queue_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic               func,
    input  logic               key_valid,
    input  logic signed [16:0] key_value,
    input  logic               mouse_valid,
    input  logic [15:0]        mouse_x,
    input  logic [15:0]        mouse_y,
    input  logic [7:0]         mouse_buttons,
    input  logic               device_select,
    input  logic [6:0]         read_limit,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic               event_valid,
    input  logic [31:0]        stamp_seconds,
    input  logic [19:0]        stamp_micros,
    input  logic [1:0]         event_kind,
    input  logic [15:0]        event_code,
    input  logic signed [16:0] event_value,
    input  logic               last_of_read,
    output int                 mismatch_count,
    output int                 events_outstanding
);

    import ireq_pkg::*;
    import ireq_tb_pkg::*;

    localparam int REPORT_LIMIT = 10;

    // one output beat, also used as a ring entry
    typedef struct packed {
        logic        ev_valid;
        logic [31:0] seconds;
        logic [19:0] micros;
        logic [1:0]  kind;
        logic [15:0] code;
        logic [16:0] value;
        logic        last;
    } event_beat_t;

    // predicted state of the block
    logic [31:0] tick_seconds;
    logic [19:0] tick_micros;
    logic [15:0] last_x;
    logic [15:0] last_y;
    logic [7:0]  known_buttons;
    event_beat_t ring_store [2*RING_SIZE];
    int          ring_rd [2];
    int          ring_wr [2];
    int          ring_fill [2];

    event_beat_t expected_events [$];

    // timestamped push into one ring, dropped when the ring is full
    task automatic push_ring_event(input int dev, input logic [1:0] kind,
                                   input logic [15:0] code, input logic [16:0] value);
        event_beat_t entry;
        if (ring_fill[dev] >= RING_SIZE)
            return;
        entry = '0;
        entry.seconds = tick_seconds;
        entry.micros  = tick_micros;
        entry.kind    = kind;
        entry.code    = code;
        entry.value   = value;
        ring_store[dev*RING_SIZE + ring_wr[dev]] = entry;
        ring_wr[dev] = (ring_wr[dev] + 1) % RING_SIZE;
        ring_fill[dev]++;
    endtask

    // poll: advance the clock, then turn the reports into ring events
    task automatic apply_poll();
        logic [16:0] key_mag;
        logic [16:0] dx;
        logic [16:0] dy;
        logic [7:0]  old_buttons;
        logic        moved;
        tick_micros = tick_micros + MICROS_STEP;
        if (tick_micros >= MICROS_WRAP)
        begin
            tick_micros  = tick_micros - MICROS_WRAP;
            tick_seconds = tick_seconds + 32'd1;
        end

        // key report, a zero value is no report
        if (key_valid && key_value != 17'sd0)
        begin
            key_mag = 17'd0 - key_value;
            if (!key_value[16])
                key_mag = key_value;
            push_ring_event(int'(DEV_KBD), KIND_KEY, key_mag[15:0], {16'd0, !key_value[16]});
            push_ring_event(int'(DEV_KBD), KIND_SYNC, 16'd0, 17'd0);
        end

        // mouse report, absolute position turned into deltas
        if (mouse_valid)
        begin
            dx = {1'b0, mouse_x} - {1'b0, last_x};
            dy = {1'b0, mouse_y} - {1'b0, last_y};
            moved = (dx != 17'd0) || (dy != 17'd0);
            old_buttons = known_buttons;
            last_x = mouse_x;
            last_y = mouse_y;
            if (moved)
            begin
                push_ring_event(int'(DEV_MOUSE), KIND_REL, CODE_AXIS_X, dx);
                push_ring_event(int'(DEV_MOUSE), KIND_REL, CODE_AXIS_Y, dy);
            end
            if (mouse_buttons[0] != old_buttons[0])
                push_ring_event(int'(DEV_MOUSE), KIND_KEY, CODE_BTN_LEFT,
                                {16'd0, mouse_buttons[0]});
            if (mouse_buttons[1] != old_buttons[1])
                push_ring_event(int'(DEV_MOUSE), KIND_KEY, CODE_BTN_RIGHT,
                                {16'd0, mouse_buttons[1]});
            known_buttons = mouse_buttons;
            if (moved || old_buttons != mouse_buttons)
                push_ring_event(int'(DEV_MOUSE), KIND_SYNC, 16'd0, 17'd0);
        end
    endtask

    // read: pop up to the saturated limit, or one empty beat
    task automatic apply_read();
        int          dev;
        int          limit;
        int          count;
        event_beat_t beat;
        dev   = (device_select == DEV_MOUSE) ? 1 : 0;
        limit = int'(read_limit);
        if (limit > MAX_READ_LIMIT)
            limit = MAX_READ_LIMIT;
        count = (limit < ring_fill[dev]) ? limit : ring_fill[dev];
        if (count == 0)
        begin
            beat = '0;
            beat.last = 1'b1;
            expected_events.push_back(beat);
            return;
        end
        for (int k = 0; k < count; k++)
        begin
            beat = ring_store[dev*RING_SIZE + ring_rd[dev]];
            beat.ev_valid = 1'b1;
            beat.last     = (k == count - 1);
            expected_events.push_back(beat);
            ring_rd[dev] = (ring_rd[dev] + 1) % RING_SIZE;
            ring_fill[dev]--;
        end
    endtask

    // compare one output beat with the oldest prediction
    task automatic check_beat();
        event_beat_t got;
        event_beat_t want;
        got = {event_valid, stamp_seconds, stamp_micros, event_kind, event_code,
               event_value, last_of_read};
        if (expected_events.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("%0t: event beat with nothing expected:", $realtime,
                         " v=%0b s=%0d us=%0d k=%0d c=%h x=%h l=%0b",
                         got.ev_valid, got.seconds, got.micros, got.kind,
                         got.code, got.value, got.last);
            return;
        end
        want = expected_events.pop_front();
        if (got !== want)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
            begin
                $display("%0t: event beat mismatch", $realtime);
                $display("  expected v=%0b s=%0d us=%0d k=%0d c=%h x=%h l=%0b",
                         want.ev_valid, want.seconds, want.micros, want.kind,
                         want.code, want.value, want.last);
                $display("  actual   v=%0b s=%0d us=%0d k=%0d c=%h x=%h l=%0b",
                         got.ev_valid, got.seconds, got.micros, got.kind,
                         got.code, got.value, got.last);
            end
        end
    endtask

    // beats are taken at the rising edge, outputs before inputs
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_seconds  = '0;
            tick_micros   = '0;
            last_x        = '0;
            last_y        = '0;
            known_buttons = '0;
            for (int d = 0; d < 2; d++)
            begin
                ring_rd[d]   = 0;
                ring_wr[d]   = 0;
                ring_fill[d] = 0;
            end
            expected_events.delete();
            events_outstanding = 0;
        end
        else
        begin
            if (out_valid && out_ready)
                check_beat();
            if (in_valid && in_ready)
            begin
                if (func == FUNC_READ)
                    apply_read();
                else
                    apply_poll();
            end
            events_outstanding = expected_events.size();
        end
    end

endmodule

### tb/input_report_to_event_queue_core_tb.sv
`timescale 1ns / 1ps
// input_report_to_event_queue_core_tb: stimulus, flow control and verdict for the core
// depends on the core, ireq_tb_pkg and event_queue_checker

module input_report_to_event_queue_core_tb;

    import ireq_tb_pkg::*;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int HOLD_OFF_BEAT   = 60;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int NUM_PHASES      = 10;
    localparam int PHASE_ITEMS     = 36;
    localparam int DRAIN_CYCLES    = 20;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic               func;
    logic               key_valid;
    logic signed [16:0] key_value;
    logic               mouse_valid;
    logic [15:0]        mouse_x;
    logic [15:0]        mouse_y;
    logic [7:0]         mouse_buttons;
    logic               device_select;
    logic [6:0]         read_limit;
    logic               out_valid;
    logic               out_ready;
    logic               event_valid;
    logic [31:0]        stamp_seconds;
    logic [19:0]        stamp_micros;
    logic [1:0]         event_kind;
    logic [15:0]        event_code;
    logic signed [16:0] event_value;
    logic               last_of_read;
    int                 mismatch_count;
    int                 events_outstanding;

    // no random idling on either side while set; the one long hold-off still applies
    logic               calm;
    // last mouse report sent, for small moves
    logic [15:0]        sent_x;
    logic [15:0]        sent_y;
    logic [7:0]         sent_buttons;

    input_report_to_event_queue_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .func          (func),
        .key_valid     (key_valid),
        .key_value     (key_value),
        .mouse_valid   (mouse_valid),
        .mouse_x       (mouse_x),
        .mouse_y       (mouse_y),
        .mouse_buttons (mouse_buttons),
        .device_select (device_select),
        .read_limit    (read_limit),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .event_valid   (event_valid),
        .stamp_seconds (stamp_seconds),
        .stamp_micros  (stamp_micros),
        .event_kind    (event_kind),
        .event_code    (event_code),
        .event_value   (event_value),
        .last_of_read  (last_of_read)
    );

    event_queue_checker i_checker (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .func               (func),
        .key_valid          (key_valid),
        .key_value          (key_value),
        .mouse_valid        (mouse_valid),
        .mouse_x            (mouse_x),
        .mouse_y            (mouse_y),
        .mouse_buttons      (mouse_buttons),
        .device_select      (device_select),
        .read_limit         (read_limit),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .event_valid        (event_valid),
        .stamp_seconds      (stamp_seconds),
        .stamp_micros       (stamp_micros),
        .event_kind         (event_kind),
        .event_code         (event_code),
        .event_value        (event_value),
        .last_of_read       (last_of_read),
        .mismatch_count     (mismatch_count),
        .events_outstanding (events_outstanding)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // one request beat: random gap, then hold until taken; called at a falling edge
    task automatic send_item(input logic f, input logic kv, input logic signed [16:0] kval,
                             input logic mv, input logic [15:0] mx, input logic [15:0] my,
                             input logic [7:0] mb, input logic ds, input logic [6:0] rl);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        func          <= f;
        key_valid     <= kv;
        key_value     <= kval;
        mouse_valid   <= mv;
        mouse_x       <= mx;
        mouse_y       <= my;
        mouse_buttons <= mb;
        device_select <= ds;
        read_limit    <= rl;
        in_valid      <= 1'b1;
        if (f == FUNC_POLL && mv)
        begin
            sent_x       = mx;
            sent_y       = my;
            sent_buttons = mb;
        end
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    // poll with random reports, mostly small moves, buttons changed about half the time
    task automatic send_random_poll();
        int                 mag;
        logic signed [16:0] kval;
        logic [15:0]        mx;
        logic [15:0]        my;
        logic [7:0]         mb;
        case ($urandom_range(0, 19))
            0: kval = 17'sd0;
            1: kval = 17'h10000;
            default:
            begin
                mag  = $urandom_range(1, 65535);
                kval = $urandom_range(0, 1) ? 17'(-mag) : 17'(mag);
            end
        endcase
        case ($urandom_range(0, 3))
            0:
            begin
                mx = sent_x;
                my = sent_y;
            end
            1:
            begin
                mx = 16'($urandom_range(0, 65535));
                my = 16'($urandom_range(0, 65535));
            end
            default:
            begin
                mx = 16'(sent_x + $urandom_range(0, 16) - 8);
                my = 16'(sent_y + $urandom_range(0, 16) - 8);
            end
        endcase
        mb = $urandom_range(0, 1) ? sent_buttons : 8'($urandom_range(0, 255));
        send_item(FUNC_POLL, $urandom_range(0, 9) != 0, kval, $urandom_range(0, 4) != 0,
                  mx, my, mb, 1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)));
    endtask

    // read from a random ring, limits over the maximum now and then
    task automatic send_random_read();
        logic [6:0] rl;
        case ($urandom_range(0, 9))
            0: rl = 7'd0;
            1: rl = 7'($urandom_range(MAX_READ_LIMIT + 1, 127));
            2: rl = MAX_READ_LIMIT;
            default: rl = 7'($urandom_range(1, MAX_READ_LIMIT));
        endcase
        send_item(FUNC_READ, 1'($urandom_range(0, 1)), 17'($urandom_range(0, 131071)),
                  1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
                  16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), rl);
    endtask

    // result side: random stall per beat, one long hold-off to back the block up
    initial
    begin
        int gap;
        int beats_taken;
        bit held_off;
        out_ready   = 1'b0;
        beats_taken = 0;
        held_off    = 0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            gap = calm ? 0 : $urandom_range(0, 6);
            if (!held_off && beats_taken >= HOLD_OFF_BEAT)
            begin
                gap      = HOLD_OFF_CYCLES;
                held_off = 1;
            end
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            beats_taken++;
            @(negedge clk);
        end
    end

    // watchdog on cycles with no beat on either channel
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("[input_report_to_event_queue_core] ERROR");
        $finish;
    end

    // stimulus and verdict
    initial
    begin
        int read_pct;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        func          = FUNC_POLL;
        key_valid     = 1'b0;
        key_value     = '0;
        mouse_valid   = 1'b0;
        mouse_x       = '0;
        mouse_y       = '0;
        mouse_buttons = '0;
        device_select = DEV_KBD;
        read_limit    = '0;
        calm          = 1'b0;
        sent_x        = '0;
        sent_y        = '0;
        sent_buttons  = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty reads on both rings, one with zero limit
        send_item(FUNC_READ, 0, 0, 0, 0, 0, 0, DEV_KBD, 7'd5);
        send_item(FUNC_READ, 0, 0, 0, 0, 0, 0, DEV_MOUSE, 7'd0);
        // key extremes; an all-zero mouse report changes nothing
        send_item(FUNC_POLL, 1, 17'sd1, 1, 16'd0, 16'd0, 8'h00, DEV_KBD, 7'd0);
        send_item(FUNC_POLL, 1, -17'sd1, 0, 0, 0, 0, DEV_KBD, 7'd0);
        send_item(FUNC_POLL, 1, 17'sd65535, 0, 0, 0, 0, DEV_KBD, 7'd0);
        send_item(FUNC_POLL, 1, -17'sd65535, 0, 0, 0, 0, DEV_KBD, 7'd0);
        // magnitude that does not fit the code field
        send_item(FUNC_POLL, 1, 17'h10000, 0, 0, 0, 0, DEV_KBD, 7'd0);
        // zero key report, full-scale motion with every button set
        send_item(FUNC_POLL, 1, 17'sd0, 1, 16'hFFFF, 16'd0, 8'hFF, DEV_KBD, 7'd0);
        // ignored key value and read fields on a poll, largest negative delta
        send_item(FUNC_POLL, 0, 17'sd1234, 1, 16'd0, 16'hFFFF, 8'h00, DEV_MOUSE, 7'd127);
        // other button bit only closes with a sync
        send_item(FUNC_POLL, 0, 0, 1, 16'd0, 16'hFFFF, 8'h04, DEV_KBD, 7'd0);
        // repeated report pushes nothing
        send_item(FUNC_POLL, 0, 0, 1, 16'd0, 16'hFFFF, 8'h04, DEV_KBD, 7'd0);
        send_item(FUNC_POLL, 0, 0, 1, 16'd0, 16'hFFFF, 8'h05, DEV_KBD, 7'd0);
        // reads: single, saturated limit, then empty again
        send_item(FUNC_READ, 0, 0, 0, 0, 0, 0, DEV_KBD, 7'd1);
        send_item(FUNC_READ, 0, 0, 0, 0, 0, 0, DEV_KBD, 7'd127);
        send_item(FUNC_READ, 0, 0, 0, 0, 0, 0, DEV_KBD, 7'd64);
        send_item(FUNC_READ, 1, 17'sd77, 1, 16'h1234, 16'h5678, 8'hAA, DEV_MOUSE, 7'd3);
        send_item(FUNC_READ, 1, -17'sd9, 1, 16'hFFFF, 16'hFFFF, 8'hFF, DEV_MOUSE, 7'd64);
        send_item(FUNC_READ, 0, 0, 0, 0, 0, 0, DEV_MOUSE, 7'd2);

        // random phases: mixed, filling the rings to overflow, draining
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase)
                1, 2, 5, 6, 7: read_pct = 8;
                3, 8:          read_pct = 70;
                default:       read_pct = 50;
            endcase
            calm = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(0, 99) < read_pct)
                    send_random_read();
                else
                    send_random_poll();
            end
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        // wait for every predicted beat, then let the last poll settle
        while (events_outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("[input_report_to_event_queue_core] OK");
        else
            $display("[input_report_to_event_queue_core] ERROR");
        $finish;
    end

endmodule

### input_report_to_event_queue_core.f
rtl/ireq_pkg.sv
rtl/ireq_ram.sv
rtl/input_report_to_event_queue_core.sv
tb/ireq_tb_pkg.sv
tb/event_queue_checker.sv
tb/input_report_to_event_queue_core_tb.sv
